// File: src/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// shared types and constants of the ordered list engine
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int LEN_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = $clog2(CAPACITY);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    CMD_INS_FIRST  = 4'd0,
    CMD_INS_END    = 4'd1,
    CMD_DEL_FIRST  = 4'd2,
    CMD_DEL_END    = 4'd3,
    CMD_INS_AFTER  = 4'd4,
    CMD_INS_BEFORE = 4'd5,
    CMD_DEL_AFTER  = 4'd6,
    CMD_DEL_BEFORE = 4'd7,
    CMD_SEARCH     = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_NO_NEIGHBOUR = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  // what the cell row does in the shift cycle
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  // per-cell shift control
  typedef struct packed {
    op_t  op;
    logic at_pos;
    logic past_pos;
  } cell_sel_t;

endpackage

// File: src/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered list of signed 32-bit values held in a row of CAPACITY
// cells, front at cell 0. A command transaction is taken when start is high
// and busy is low. In that accept cycle the key is broadcast to all cells,
// each cell compares, and a priority pick finds the first match from the
// front; the plan is registered. In the next cycle (busy high) every cell
// shifts left, shifts right, loads the new value or holds, all at once. The
// result is on status/found/length/removed_value with done high for exactly
// one cycle, and the receiver cannot stall it; a new command may be accepted
// in that same cycle. Each command passes through the compare/pick cycle
// followed by the shift cycle of the cell row. No clearing pass after reset:
// the list simply starts with length zero.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [3:0]                command,
  input  logic [ole_pkg::VAL_W-1:0] key_value,
  input  logic [ole_pkg::VAL_W-1:0] new_value,
  output logic                      done,
  output logic [2:0]                status,
  output logic                      found,
  output logic [ole_pkg::LEN_W-1:0] length,
  output logic [ole_pkg::VAL_W-1:0] removed_value
);
  import ole_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SHIFT = 2'b10
  } state_t;

  state_t state;

  // list length
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // registered plan, valid during the shift cycle
  op_t              op_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] ins_q;
  status_t          status_q;
  logic             found_q;

  // plan computed in the accept cycle
  op_t              op_c;
  logic [POS_W-1:0] pos_c;
  logic [VAL_W-1:0] ins_c;
  status_t          status_c;
  logic             found_c;

  // cell row
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] hit_v;
  cell_sel_t        cell_sel [CAPACITY];
  logic [POS_W-1:0] first_pos;
  logic             any_hit;

  wire accept = start && (state == S_IDLE);

  assign busy = (state == S_SHIFT);

  // ---- cell chain ----------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cells
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    // positions are compared against the registered pick
    assign cell_sel[i].op       = (state == S_SHIFT) ? op_q : OP_NONE;
    assign cell_sel[i].at_pos   = (pos_q == POS_W'(i));
    assign cell_sel[i].past_pos = (pos_q < POS_W'(i));

    ole_cell u_cell (
      .clk        (clk),
      .sel        (cell_sel[i]),
      .ins_value  (ins_q),
      .left_value (left_v),
      .right_value(right_v),
      .key        (key_value),
      .value      (cell_val[i]),
      .hit        (cell_hit[i])
    );
  end

  // ---- first match pick ----------------------------------------------------
  // only cells below the length take part
  always_comb begin
    first_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      hit_v[i] = cell_hit[i] && (CNT_W'(i) < cnt);
      if (hit_v[i]) begin
        first_pos = POS_W'(i);
      end
    end
    any_hit = |hit_v;
  end

  // ---- command decode ------------------------------------------------------
  always_comb begin
    op_c     = OP_NONE;
    pos_c    = '0;
    ins_c    = key_value;
    status_c = ST_OK;
    found_c  = 1'b0;
    unique case (cmd_t'(command)) inside
      CMD_INS_FIRST, CMD_INS_END: begin
        if (cnt == CAP_CNT) begin
          status_c = ST_FULL;
        end else begin
          op_c  = OP_INS;
          pos_c = (cmd_t'(command) == CMD_INS_FIRST) ? '0 : POS_W'(cnt);
        end
      end
      CMD_DEL_FIRST, CMD_DEL_END: begin
        if (cnt == '0) begin
          status_c = ST_EMPTY;
        end else begin
          op_c  = OP_DEL;
          pos_c = (cmd_t'(command) == CMD_DEL_FIRST) ? '0 :
                  POS_W'(cnt - CNT_W'(1));
        end
      end
      CMD_INS_AFTER, CMD_INS_BEFORE, CMD_DEL_AFTER, CMD_DEL_BEFORE,
      CMD_SEARCH: begin
        if (cnt == '0) begin
          status_c = ST_EMPTY;
        end else if (!any_hit) begin
          status_c = ST_NOT_FOUND;
        end else begin
          found_c = 1'b1;
          ins_c   = new_value;
          case (cmd_t'(command))
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
              if (cnt == CAP_CNT) begin
                status_c = ST_FULL;
              end else begin
                op_c  = OP_INS;
                pos_c = (cmd_t'(command) == CMD_INS_AFTER) ?
                        first_pos + POS_W'(1) : first_pos;
              end
            end
            CMD_DEL_AFTER: begin
              if (CNT_W'(first_pos) + CNT_W'(1) >= cnt) begin
                status_c = ST_NO_NEIGHBOUR;
              end else begin
                op_c  = OP_DEL;
                pos_c = first_pos + POS_W'(1);
              end
            end
            CMD_DEL_BEFORE: begin
              if (first_pos == '0) begin
                status_c = ST_NO_NEIGHBOUR;
              end else begin
                op_c  = OP_DEL;
                pos_c = first_pos - POS_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
  end

  // ---- length update -------------------------------------------------------
  always_comb begin
    case (op_q)
      OP_INS:  cnt_next = cnt + CNT_W'(1);
      OP_DEL:  cnt_next = cnt - CNT_W'(1);
      default: cnt_next = cnt;
    endcase
  end

  // ---- control -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      op_q  <= OP_NONE;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SHIFT;
            op_q  <= op_c;
          end
        end
        S_SHIFT: begin
          state <= S_IDLE;
          cnt   <= cnt_next;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- plan and result payload ---------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q    <= pos_c;
      ins_q    <= ins_c;
      status_q <= status_c;
      found_q  <= found_c;
    end
    if (state == S_SHIFT) begin
      status        <= status_q;
      found         <= found_q;
      length        <= LEN_W'(cnt_next);
      // removed entry is read before the row shifts over it
      removed_value <= (op_q == OP_DEL) ? cell_val[pos_q] : '0;
    end
  end

  // ---- checks --------------------------------------------------------------
  a_shift_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("shift cycle did not follow an accepted transaction");

  a_one_shift_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("shift cycle did not end in exactly one result");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_CNT)
    else $error("list length beyond capacity");

  a_refused_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (cnt == $past(cnt)))
    else $error("refused transaction changed the list length");

  a_empty_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY || status == ST_NOT_FOUND)) |->
      (!found && removed_value == '0))
    else $error("empty or not-found result reports a match or removal");

endmodule

// File: src/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// one list slot: holds a value, compares it with the key, shifts with neighbors
// ----------------------------------------------------------------------------
module ole_cell (
  input  logic                      clk,
  input  ole_pkg::cell_sel_t        sel,
  input  logic [ole_pkg::VAL_W-1:0] ins_value,
  input  logic [ole_pkg::VAL_W-1:0] left_value,
  input  logic [ole_pkg::VAL_W-1:0] right_value,
  input  logic [ole_pkg::VAL_W-1:0] key,
  output logic [ole_pkg::VAL_W-1:0] value,
  output logic                      hit
);
  import ole_pkg::*;

  always_ff @(posedge clk) begin
    case (sel.op)
      OP_INS: begin
        if (sel.at_pos) begin
          value <= ins_value;
        end else if (sel.past_pos) begin
          value <= left_value;
        end
      end
      OP_DEL: begin
        if (sel.at_pos || sel.past_pos) begin
          value <= right_value;
        end
      end
      default: begin
      end
    endcase
  end

  assign hit = (value == key);

endmodule
